[sv/tked_pkg.sv]
// ----------------------------------------------------------------------------
// tked_pkg
// Shared types, codes and decode helpers of the terminal key escape decoder.
// ----------------------------------------------------------------------------
package tked_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_ESC       = 3'd1,
      MODE_CSI_FIRST = 3'd2,
      MODE_CSI_BODY  = 3'd3,
      MODE_SS3       = 3'd4
   } mode_type;

   typedef enum logic [4:0] {
      KEY_CHAR       = 5'd0,
      KEY_ENTER      = 5'd1,
      KEY_BACKSPACE  = 5'd2,
      KEY_CTRL_A     = 5'd3,
      KEY_CTRL_C     = 5'd4,
      KEY_CTRL_D     = 5'd5,
      KEY_CTRL_E     = 5'd6,
      KEY_TAB        = 5'd7,
      KEY_ESCAPE     = 5'd8,
      KEY_UP         = 5'd9,
      KEY_DOWN       = 5'd10,
      KEY_RIGHT      = 5'd11,
      KEY_LEFT       = 5'd12,
      KEY_HOME       = 5'd13,
      KEY_END        = 5'd14,
      KEY_DELETE     = 5'd15,
      KEY_WORD_LEFT  = 5'd16,
      KEY_WORD_RIGHT = 5'd17,
      KEY_UNKNOWN    = 5'd18,
      KEY_EOF        = 5'd19
   } key_type;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_EOF  = 2'd2;

   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_DEL    = 8'h7F;
   localparam logic [7:0] BYTE_BS     = 8'h08;
   localparam logic [7:0] BYTE_CTRL_A = 8'h01;
   localparam logic [7:0] BYTE_CTRL_C = 8'h03;
   localparam logic [7:0] BYTE_CTRL_D = 8'h04;
   localparam logic [7:0] BYTE_CTRL_E = 8'h05;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_ESC    = 8'h1B;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
   localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;

   function automatic key_type letter_key(input logic [7:0] b);
      key_type k;
      case (b)
         "A":     k = KEY_UP;
         "B":     k = KEY_DOWN;
         "C":     k = KEY_RIGHT;
         "D":     k = KEY_LEFT;
         "H":     k = KEY_HOME;
         "F":     k = KEY_END;
         default: k = KEY_UNKNOWN;
      endcase
      return k;
   endfunction

   // classify a collected csi body from its length flags and first four bytes
   function automatic key_type classify_csi(input logic is1, input logic is2,
                                            input logic is4,
                                            input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
      key_type k;
      k = KEY_UNKNOWN;
      if (is1) begin
         k = letter_key(b0);
      end else if (is2 && b0 == "3" && b1 == "~") begin
         k = KEY_DELETE;
      end else if (is4 && b0 == "1" && b1 == ";" && (b2 == "3" || b2 == "5")) begin
         if (b3 == "C") begin
            k = KEY_WORD_RIGHT;
         end else if (b3 == "D") begin
            k = KEY_WORD_LEFT;
         end
      end
      return k;
   endfunction

endpackage

[sv/terminal_key_escape_decoder.sv]
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// Turns raw terminal bytes, idle ticks and end of input into key events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = request kind (0 byte, 1 idle tick, 2 end of input,
//   3 ignored), tdata = received byte. rsp channel: tuser = key kind,
//   tdata = character code (zero unless the key is a char event).
//   A request gives zero or one response; ticks while idle and bytes that
//   start or extend an escape sequence give none.
//   A request taken is held in the input register and decoded into the
//   response register once that register is empty or being read, so a
//   stall of the receiver can keep it waiting in the input register.
//   Throughput: one request per cycle when the receiver does not stall,
//   set by the single decode step between the input and response registers.
//   csr_we/csr_wdata write timeout_ticks (idle ticks per awaited escape
//   byte, reset 50); write it only while the block is idle.
//   Reset clears the parser to idle, empties both registers and restores
//   the timeout. When the receiver stalls, the pending response holds, the
//   input register still accepts one more request, then req_tready drops.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder #(
   parameter int SEQ_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_code
   output logic [4:0]  rsp_tuser,   // [4:0] key_kind
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import tked_pkg::*;

   localparam int CW = $clog2(SEQ_DEPTH + 1);

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_type_ff;
   logic [7:0]  in_byte_ff;

   // parser state
   mode_type    mode_ff, mode_in;
   logic [15:0] wait_ff, wait_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]  seq_bytes_ff [SEQ_DEPTH];
   logic [15:0] timeout_ff;

   // response register
   logic        rsp_valid_ff;
   key_type     rsp_kind_ff;
   logic [7:0]  rsp_code_ff;

   logic        fire;
   logic        emit;
   key_type     kind;
   logic [7:0]  code;
   logic        csi_store;
   logic [CW-1:0] cnt_base;
   logic [CW-1:0] cnt_next;
   logic [7:0]  view [4];
   logic [16:0] wait_inc;
   logic        is_final;
   key_type     held_class;
   key_type     new_class;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_code_ff;

   assign cnt_base = (mode_ff == MODE_CSI_FIRST) ? '0 : cnt_ff;
   assign cnt_next = cnt_base + CW'(1);
   assign wait_inc = {1'b0, wait_ff} + 17'd1;
   assign is_final = (in_byte_ff >= BYTE_FINAL_LO) && (in_byte_ff <= BYTE_FINAL_HI);

   // first four bytes of the csi body as it stands once the current byte is added
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         view[k] = (cnt_base == CW'(k)) ? in_byte_ff : seq_bytes_ff[k];
      end
   end

   assign held_class = classify_csi(cnt_ff == CW'(1), cnt_ff == CW'(2), cnt_ff == CW'(4),
                                    seq_bytes_ff[0], seq_bytes_ff[1],
                                    seq_bytes_ff[2], seq_bytes_ff[3]);
   assign new_class  = classify_csi(cnt_next == CW'(1), cnt_next == CW'(2),
                                    cnt_next == CW'(4),
                                    view[0], view[1], view[2], view[3]);

   always_comb begin
      mode_in   = mode_ff;
      wait_in   = wait_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      kind      = KEY_UNKNOWN;
      code      = 8'd0;
      csi_store = 1'b0;
      case (in_type_ff)
         REQ_BYTE: begin
            case (mode_ff)
               MODE_ESC: begin
                  if (in_byte_ff == "[") begin
                     mode_in = MODE_CSI_FIRST;
                     wait_in = '0;
                     cnt_in  = '0;
                  end else if (in_byte_ff == "O") begin
                     mode_in = MODE_SS3;
                     wait_in = '0;
                  end else begin
                     emit    = 1'b1;
                     kind    = (in_byte_ff == "b") ? KEY_WORD_LEFT :
                               (in_byte_ff == "f") ? KEY_WORD_RIGHT : KEY_ESCAPE;
                     mode_in = MODE_IDLE;
                     wait_in = '0;
                     cnt_in  = '0;
                  end
               end
               MODE_CSI_FIRST, MODE_CSI_BODY: begin
                  csi_store = (cnt_base < CW'(SEQ_DEPTH));
                  if (is_final || cnt_next >= CW'(SEQ_DEPTH)) begin
                     emit    = 1'b1;
                     kind    = new_class;
                     mode_in = MODE_IDLE;
                     wait_in = '0;
                     cnt_in  = '0;
                  end else begin
                     mode_in = MODE_CSI_BODY;
                     wait_in = '0;
                     cnt_in  = cnt_next;
                  end
               end
               MODE_SS3: begin
                  emit    = 1'b1;
                  kind    = letter_key(in_byte_ff);
                  mode_in = MODE_IDLE;
                  wait_in = '0;
                  cnt_in  = '0;
               end
               default: begin
                  mode_in = MODE_IDLE;
                  wait_in = '0;
                  cnt_in  = '0;
                  emit    = 1'b1;
                  case (in_byte_ff)
                     BYTE_CR, BYTE_LF: kind = KEY_ENTER;
                     BYTE_DEL, BYTE_BS: kind = KEY_BACKSPACE;
                     BYTE_CTRL_A: kind = KEY_CTRL_A;
                     BYTE_CTRL_C: kind = KEY_CTRL_C;
                     BYTE_CTRL_D: kind = KEY_CTRL_D;
                     BYTE_CTRL_E: kind = KEY_CTRL_E;
                     BYTE_TAB:    kind = KEY_TAB;
                     BYTE_ESC: begin
                        emit    = 1'b0;
                        mode_in = MODE_ESC;
                     end
                     default: begin
                        if (in_byte_ff >= BYTE_SPACE) begin
                           kind = KEY_CHAR;
                           code = in_byte_ff;
                        end else begin
                           kind = KEY_UNKNOWN;
                        end
                     end
                  endcase
               end
            endcase
         end
         REQ_TICK, REQ_EOF: begin
            if (mode_ff == MODE_IDLE) begin
               if (in_type_ff == REQ_EOF) begin
                  emit    = 1'b1;
                  kind    = KEY_EOF;
                  wait_in = '0;
                  cnt_in  = '0;
               end
            end else if (in_type_ff == REQ_EOF || wait_inc >= {1'b0, timeout_ff}) begin
               // wait abandoned: timeout or end of input
               emit = 1'b1;
               case (mode_ff)
                  MODE_CSI_FIRST: kind = KEY_UNKNOWN;
                  MODE_CSI_BODY:  kind = held_class;
                  default:        kind = KEY_ESCAPE;
               endcase
               mode_in = MODE_IDLE;
               wait_in = '0;
               cnt_in  = '0;
            end else begin
               wait_in = wait_inc[15:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_IDLE;
         wait_ff      <= '0;
         cnt_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            mode_ff      <= mode_in;
            wait_ff      <= wait_in;
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (fire && emit) begin
         rsp_kind_ff <= kind;
         rsp_code_ff <= code;
      end
      for (int i = 0; i < SEQ_DEPTH; i++) begin
         if (fire && csi_store && cnt_base == CW'(i)) begin
            seq_bytes_ff[i] <= in_byte_ff;
         end
      end
   end

endmodule

[sv/tked_checker.sv]
// ----------------------------------------------------------------------------
// tked_checker
// Port-level checks on the response channel of the key escape decoder.
// ----------------------------------------------------------------------------
module tked_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [4:0]  rsp_tuser
);
   import tked_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= KEY_EOF)
      else $error("key kind out of range");

   // only char events carry a byte, and it is printable or above
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KEY_CHAR |-> rsp_tdata == 8'd0)
      else $error("nonzero code on a non-char key");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KEY_CHAR |-> rsp_tdata >= BYTE_SPACE)
      else $error("char event below space");

endmodule

bind terminal_key_escape_decoder tked_checker u_tked_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
